FILE: src/wildcard_glob_matcher_assert.svh
// assertion macros for the glob matcher
// no dependencies; included by the top level only
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// property holds on every clock edge outside reset
`define WGM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("wgm check failed");

// antecedent on one edge implies consequent on the next
`define WGM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wgm check failed");

`else

`define WGM_ASSERT(label, prop)
`define WGM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/wgm_pkg.sv
// shared types and constants for the glob matcher
// no dependencies
package wgm_pkg;

   localparam int unsigned MAX_PATTERN_DEFAULT = 64;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   localparam logic [7:0] CHAR_STAR = 8'd42;
   localparam logic [7:0] CHAR_ANY  = 8'd63;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic       rearm;
      logic       step;
      logic [7:0] char_code;
   } cell_ctrl_type;

endpackage

FILE: src/wgm_cell.sv
// one pattern position: stored byte and its prefix-active bit
// depends on wgm_pkg
module wgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wgm_pkg::cell_ctrl_type ctrl,
   input  logic                  head,
   input  logic                  wr_en,
   input  logic                  used,
   input  logic                  carry_in,
   input  logic                  fwd_in,
   output logic                  closed,
   output logic                  carry_out,
   output logic                  fwd_out
);
   import wgm_pkg::*;

   logic [7:0] byte_ff;
   logic       base_ff;
   logic       base_in;
   logic       is_star;
   logic       hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_ff <= ctrl.char_code;
      end
   end

   // active after skipping a run of stars in front of this position
   assign closed    = base_ff | carry_in;
   assign is_star   = used & (byte_ff == CHAR_STAR);
   assign carry_out = closed & is_star;
   assign hit       = (byte_ff == CHAR_ANY) | (byte_ff == ctrl.char_code);
   assign fwd_out   = closed & used & ~is_star & hit;

   always_comb begin
      if (ctrl.rearm) begin
         base_in = head;
      end else if (ctrl.step) begin
         // a star keeps itself active on any text byte
         base_in = carry_out | fwd_in;
      end else begin
         base_in = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= head;
      end else begin
         base_ff <= base_in;
      end
   end

endmodule

FILE: src/wgm_chain.sv
// row of pattern cells plus the final full-match position
// depends on wgm_pkg and wgm_cell
module wgm_chain #(
   parameter int unsigned MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wgm_pkg::cell_ctrl_type ctrl,
   input  logic [MAX_PATTERN-1:0] wr_en,
   input  logic [MAX_PATTERN-1:0] used,
   output logic [MAX_PATTERN:0]   closed
);
   import wgm_pkg::*;

   logic [MAX_PATTERN:0] carry;
   logic [MAX_PATTERN:0] fwd;
   logic                 tail_ff;
   logic                 tail_in;

   assign carry[0] = 1'b0;
   assign fwd[0]   = 1'b0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      wgm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .head      (i == 0),
         .wr_en     (wr_en[i]),
         .used      (used[i]),
         .carry_in  (carry[i]),
         .fwd_in    (fwd[i]),
         .closed    (closed[i]),
         .carry_out (carry[i+1]),
         .fwd_out   (fwd[i+1])
      );
   end

   // position past the last byte: whole pattern consumed
   assign closed[MAX_PATTERN] = tail_ff | carry[MAX_PATTERN];

   always_comb begin
      if (ctrl.rearm) begin
         tail_in = 1'b0;
      end else if (ctrl.step) begin
         tail_in = fwd[MAX_PATTERN];
      end else begin
         tail_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= 1'b0;
      end else begin
         tail_ff <= tail_in;
      end
   end

endmodule

FILE: src/wildcard_glob_matcher.sv
// Glob matcher: load a pattern byte by byte ('*' any run, '?' any byte), stream text
// bytes, and an end-of-text beat returns matched plus the overflow flag. A new beat
// is taken each cycle unless an end-of-text beat must wait; the result sits in
// an output register from the next cycle on. The cycle is set by the row of pattern
// cells: the star-skip through consecutive '*' bytes ripples cell to cell, like a
// carry chain, MAX_PATTERN cells long. Non-result beats are still taken while a
// result waits; an end-of-text beat waits only for the output register to free up.
// There is no clearing pass after reset.
`include "wildcard_glob_matcher_assert.svh"
module wildcard_glob_matcher #(
   parameter int unsigned MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wgm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wgm_pkg::rsp_type rsp_data
);
   import wgm_pkg::*;

   localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

   logic [LW-1:0]          len_ff;
   logic [LW-1:0]          len_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;
   logic                   fire;
   logic                   full;
   logic                   append_fire;
   logic                   end_fire;
   cell_ctrl_type          ctrl;
   logic [MAX_PATTERN-1:0] wr_en;
   logic [MAX_PATTERN-1:0] used;
   logic [MAX_PATTERN:0]   closed;

   assign req_ready = rsp_ready | ~rsp_valid_ff | (req_data.opcode != OP_END);
   assign fire        = req_valid & req_ready;
   assign full        = (len_ff == LW'(MAX_PATTERN));
   assign append_fire = fire & (req_data.opcode == OP_APPEND);
   assign end_fire    = fire & (req_data.opcode == OP_END);

   assign ctrl.rearm     = fire & (req_data.opcode != OP_TEXT);
   assign ctrl.step      = fire & (req_data.opcode == OP_TEXT);
   assign ctrl.char_code = req_data.char_code;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_dec
      assign used[i]  = len_ff > LW'(i);
      assign wr_en[i] = append_fire & (len_ff == LW'(i));
   end

   wgm_chain #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .wr_en  (wr_en),
      .used   (used),
      .closed (closed)
   );

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (fire) begin
         case (req_data.opcode)
            OP_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
            end
            OP_APPEND: begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  len_in = len_ff + LW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = end_fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_fire) begin
         rsp_data_ff.matched          <= closed[len_ff];
         rsp_data_ff.pattern_overflow <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WGM_ASSERT_NEXT(a_end_gives_beat, end_fire, rsp_valid_ff)
   `WGM_ASSERT_NEXT(a_full_sets_ovf, append_fire && full, ovf_ff && (len_ff == LW'(MAX_PATTERN)))
   `WGM_ASSERT_NEXT(a_append_grows, append_fire && !full, len_ff == $past(len_ff) + LW'(1))
   `WGM_ASSERT_NEXT(a_clear_empties, fire && (req_data.opcode == OP_CLEAR), (len_ff == '0) && !ovf_ff)

endmodule
